>>> src/lrps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDPC rate pair search - shared types and constants
// Beat structures, pair tables and constant reciprocals for the row weights.
// ----------------------------------------------------------------------------
package lrps_pkg;

    localparam int CAP_BITS    = 18;
    localparam int NUM_PAIRS   = 21;
    localparam int NUM_DIV     = 6;
    localparam int DIV_FIRST   = 4;
    localparam int RECIP_SHIFT = CAP_BITS + 4;
    localparam int RECIP_BITS  = RECIP_SHIFT - 1;
    localparam int PROD_BITS   = CAP_BITS + RECIP_SHIFT;
    localparam int PAY_BITS    = CAP_BITS + 3;

    typedef struct packed {
        logic [CAP_BITS-1:0] capacity;
        logic [CAP_BITS-1:0] net_length;
    } cmd_t;

    typedef struct packed {
        logic                found;
        logic [3:0]          col_weight;
        logic [3:0]          row_weight;
        logic [CAP_BITS-1:0] slack;
    } result_t;

    typedef struct packed {
        logic                ok;
        logic [3:0]          wc;
        logic [3:0]          wr;
        logic [CAP_BITS-1:0] slack;
    } cand_t;

    // search order: wc ascending, then wr ascending
    localparam logic [3:0] PAIR_WC [NUM_PAIRS] = '{
        4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd5, 4'd5,
        4'd6, 4'd6, 4'd6,
        4'd7, 4'd7,
        4'd8
    };

    localparam logic [3:0] PAIR_WR [NUM_PAIRS] = '{
        4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
        4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
        4'd6, 4'd7, 4'd8, 4'd9,
        4'd7, 4'd8, 4'd9,
        4'd8, 4'd9,
        4'd9
    };

    // ceil(2^RECIP_SHIFT / d): exact floor(x/d) for any x below 2^CAP_BITS
    localparam logic [RECIP_BITS-1:0] RECIP [NUM_DIV] = '{
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd3) / 64'd4),
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5),
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6),
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd6) / 64'd7),
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd7) / 64'd8),
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9)
    };

    // left side wins ties: it is earlier in search order
    function automatic cand_t cand_pick(input cand_t a, input cand_t b);
        cand_t r;
        r = a;
        if (b.ok && (!a.ok || (b.slack < a.slack))) begin
            r = b;
        end
        return r;
    endfunction

endpackage

>>> src/lrps_quot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDPC rate pair search - quotient stage
// Registers capacity times the reciprocal of each row weight 4..9; the
// quotients are the upper bits of the registered products.
// ----------------------------------------------------------------------------
module lrps_quot (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  lrps_pkg::cmd_t                 cmd,
    output logic                           out_valid,
    output lrps_pkg::cmd_t                 cmd_out,
    output logic [lrps_pkg::CAP_BITS-1:0]  quot [lrps_pkg::NUM_DIV]
);

    logic                             valid_reg;
    lrps_pkg::cmd_t                   cmd_reg;
    logic [lrps_pkg::PROD_BITS-1:0]   prod_reg  [lrps_pkg::NUM_DIV];
    logic [lrps_pkg::PROD_BITS-1:0]   prod_next [lrps_pkg::NUM_DIV];

    always_comb
    begin
        for (int i = 0; i < lrps_pkg::NUM_DIV; i++)
        begin
            prod_next[i] = lrps_pkg::PROD_BITS'(cmd.capacity) *
                           lrps_pkg::PROD_BITS'(lrps_pkg::RECIP[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        for (int i = 0; i < lrps_pkg::NUM_DIV; i++)
        begin
            quot[i] = prod_reg[i][lrps_pkg::RECIP_SHIFT +: lrps_pkg::CAP_BITS];
        end
    end

    assign out_valid = valid_reg;
    assign cmd_out   = cmd_reg;

endmodule

>>> src/ldpc_rate_pair_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDPC rate pair search
// Picks the (wc, wr) pair with the smallest non-negative slack below capacity.
// Done pulses once the start beat has passed the quotient, candidate, s3, s4 and result registers.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Stages: reciprocal multiply, payload and slack per pair, three min-tree stages.
// Reset: valid bits clear asynchronously; beats in flight are dropped.
// ----------------------------------------------------------------------------
module ldpc_rate_pair_search (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lrps_pkg::cmd_t      cmd,
    output logic                done,
    output lrps_pkg::result_t   result
);

    logic                            q_valid;
    lrps_pkg::cmd_t                  q_cmd;
    logic [lrps_pkg::CAP_BITS-1:0]   quot [lrps_pkg::NUM_DIV];

    lrps_pkg::cand_t   cand_reg  [lrps_pkg::NUM_PAIRS];
    lrps_pkg::cand_t   cand_next [lrps_pkg::NUM_PAIRS];
    logic              cand_valid_reg;

    lrps_pkg::cand_t   lvl1 [11];
    lrps_pkg::cand_t   lvl2 [6];
    lrps_pkg::cand_t   s3_reg [6];
    logic              s3_valid_reg;

    lrps_pkg::cand_t   lvl3 [3];
    lrps_pkg::cand_t   lvl4 [2];
    lrps_pkg::cand_t   s4_reg [2];
    logic              s4_valid_reg;

    lrps_pkg::cand_t   best;
    lrps_pkg::result_t result_next;
    lrps_pkg::result_t result_reg;
    logic              done_reg;

    assign busy = 1'b0;

    lrps_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .cmd       (cmd),
        .out_valid (q_valid),
        .cmd_out   (q_cmd),
        .quot      (quot)
    );

    // payload = floor(cap/wr) * (wr - wc), slack = payload - net
    always_comb
    begin
        logic [lrps_pkg::PAY_BITS-1:0] pay;
        logic [lrps_pkg::PAY_BITS-1:0] net_w;
        logic [lrps_pkg::PAY_BITS-1:0] cap_w;
        logic [lrps_pkg::PAY_BITS-1:0] diff;
        logic [3:0]                    k;
        logic [3:0]                    d_idx;
        net_w = lrps_pkg::PAY_BITS'(q_cmd.net_length);
        cap_w = lrps_pkg::PAY_BITS'(q_cmd.capacity);
        for (int i = 0; i < lrps_pkg::NUM_PAIRS; i++)
        begin
            k     = lrps_pkg::PAIR_WR[i] - lrps_pkg::PAIR_WC[i];
            d_idx = lrps_pkg::PAIR_WR[i] - 4'(lrps_pkg::DIV_FIRST);
            pay   = lrps_pkg::PAY_BITS'(quot[d_idx[2:0]]) *
                    lrps_pkg::PAY_BITS'(k);
            diff  = pay - net_w;
            cand_next[i].ok    = (pay >= net_w) && (diff < cap_w);
            cand_next[i].wc    = lrps_pkg::PAIR_WC[i];
            cand_next[i].wr    = lrps_pkg::PAIR_WR[i];
            cand_next[i].slack = diff[lrps_pkg::CAP_BITS-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            lvl1[i] = lrps_pkg::cand_pick(cand_reg[2*i], cand_reg[2*i+1]);
        end
        lvl1[10] = cand_reg[20];
        for (int i = 0; i < 5; i++)
        begin
            lvl2[i] = lrps_pkg::cand_pick(lvl1[2*i], lvl1[2*i+1]);
        end
        lvl2[5] = lvl1[10];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lvl3[i] = lrps_pkg::cand_pick(s3_reg[2*i], s3_reg[2*i+1]);
        end
        lvl4[0] = lrps_pkg::cand_pick(lvl3[0], lvl3[1]);
        lvl4[1] = lvl3[2];
    end

    always_comb
    begin
        best = lrps_pkg::cand_pick(s4_reg[0], s4_reg[1]);
        result_next.found      = best.ok;
        result_next.col_weight = best.ok ? best.wc : 4'd0;
        result_next.row_weight = best.ok ? best.wr : 4'd0;
        result_next.slack      = best.ok ? best.slack : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_valid_reg <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            cand_valid_reg <= q_valid;
            s3_valid_reg   <= cand_valid_reg;
            s4_valid_reg   <= s3_valid_reg;
            done_reg       <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        s3_reg     <= lvl2;
        s4_reg     <= lvl4;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> src/lrps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDPC rate pair search - port checker
// Watches the top-level ports for latency and result consistency.
// ----------------------------------------------------------------------------
module lrps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input lrps_pkg::cmd_t      cmd,
    input logic                done,
    input lrps_pkg::result_t   result
);

    // fixed latency, both ways
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("beat taken without result five cycles later");

    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result with no matching beat");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |->
            (result.col_weight == 4'd0 && result.row_weight == 4'd0 &&
             result.slack == '0))
        else $error("not-found result carries nonzero fields");

    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |->
            (result.col_weight >= 4'd3 && result.col_weight <= 4'd8 &&
             result.row_weight > result.col_weight && result.row_weight <= 4'd9))
        else $error("pair outside search range");

    a_slack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> (result.slack < $past(cmd.capacity, 5)))
        else $error("slack not below capacity");

endmodule

bind ldpc_rate_pair_search lrps_checker u_lrps_checker (.*);
